// ===== rtl/i2cmbe_pkg.sv =====
`timescale 1ns / 1ps

package i2cmbe_pkg;

	// one tick as it enters the engine
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_t;

	// pin drive and status after one tick
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} result_t;

	localparam int CfgWidth = 16;

	// configuration register indexes
	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd1;
	localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

endpackage

// ===== rtl/i2cmbe_seq.sv =====
`timescale 1ns / 1ps

module i2cmbe_seq import i2cmbe_pkg::*; #(
	parameter int DELAY_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  tick_t       tick,
	input  logic [15:0] half_period,
	input  logic [7:0]  ack_timeout,
	output result_t     res
);

	localparam logic [2:0] OP_START    = 3'd0;
	localparam logic [2:0] OP_STOP     = 3'd1;
	localparam logic [2:0] OP_WRITE    = 3'd2;
	localparam logic [2:0] OP_WAIT_ACK = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [3:0] {
		PH_IDLE, PH_S_A, PH_S_B, PH_P_A, PH_P_B,
		PH_W_LOW, PH_W_HIGH, PH_W_TAIL,
		PH_R_LOW, PH_R_HIGH, PH_A_LOW, PH_A_HIGH,
		PH_K_REL, PH_K_HIGH, PH_K_POLL
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [3:0]             bit_cnt_q, bit_cnt_n;
	logic [7:0]             shift_q, shift_n;
	logic [DELAY_WIDTH-1:0] delay_q, delay_n;
	logic [7:0]             poll_q, poll_n;
	logic                   ack_choice_q, ack_choice_n;
	logic                   scl_q, scl_n;
	logic                   sda_q, sda_n;
	logic                   fail_q, fail_n;
	logic [7:0]             rx_q, rx_n;
	logic                   done_q, done_n;

	logic [DELAY_WIDTH-1:0] hp_trunc;
	logic [DELAY_WIDTH-1:0] delay_load;
	logic                   do_poll;

	assign hp_trunc   = DELAY_WIDTH'(half_period);
	// a zero interval still lasts one tick
	assign delay_load = (hp_trunc == '0) ? DELAY_WIDTH'(1) : hp_trunc;

	always_comb begin
		phase_n      = phase_q;
		bit_cnt_n    = bit_cnt_q;
		shift_n      = shift_q;
		delay_n      = delay_q;
		poll_n       = poll_q;
		ack_choice_n = ack_choice_q;
		scl_n        = scl_q;
		sda_n        = sda_q;
		fail_n       = fail_q;
		rx_n         = rx_q;
		done_n       = 1'b0;
		do_poll      = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (tick.cmd_valid) begin
				unique case (tick.op)
					OP_START: begin
						sda_n   = 1'b1;
						scl_n   = 1'b1;
						delay_n = delay_load;
						phase_n = PH_S_A;
					end
					OP_STOP: begin
						scl_n   = 1'b0;
						sda_n   = 1'b0;
						delay_n = delay_load;
						phase_n = PH_P_A;
					end
					OP_WRITE: begin
						scl_n     = 1'b0;
						sda_n     = tick.tx_byte[7];
						shift_n   = {tick.tx_byte[6:0], 1'b0};
						bit_cnt_n = 4'd1;
						delay_n   = delay_load;
						phase_n   = PH_W_LOW;
					end
					OP_WAIT_ACK: begin
						fail_n  = 1'b0;
						poll_n  = '0;
						sda_n   = 1'b1;
						delay_n = delay_load;
						phase_n = PH_K_REL;
					end
					OP_READ: begin
						sda_n        = 1'b1;
						scl_n        = 1'b0;
						shift_n      = '0;
						bit_cnt_n    = '0;
						ack_choice_n = tick.send_ack;
						delay_n      = delay_load;
						phase_n      = PH_R_LOW;
					end
					default: ;
				endcase
			end
		end else if (phase_q == PH_K_POLL) begin
			do_poll = 1'b1;
		end else if (delay_q <= DELAY_WIDTH'(1)) begin
			delay_n = '0;
			unique case (phase_q)
				PH_S_A: begin
					sda_n   = 1'b0;
					delay_n = delay_load;
					phase_n = PH_S_B;
				end
				PH_S_B: begin
					scl_n   = 1'b0;
					phase_n = PH_IDLE;
					done_n  = 1'b1;
				end
				PH_P_A: begin
					scl_n   = 1'b1;
					delay_n = delay_load;
					phase_n = PH_P_B;
				end
				PH_P_B: begin
					sda_n   = 1'b1;
					phase_n = PH_IDLE;
					done_n  = 1'b1;
				end
				PH_W_LOW: begin
					scl_n   = 1'b1;
					delay_n = delay_load;
					phase_n = PH_W_HIGH;
				end
				PH_W_HIGH: begin
					scl_n   = 1'b0;
					delay_n = delay_load;
					phase_n = PH_W_TAIL;
				end
				PH_W_TAIL: begin
					if (bit_cnt_q >= BITS_PER_BYTE) begin
						phase_n = PH_IDLE;
						done_n  = 1'b1;
					end else begin
						sda_n     = shift_q[7];
						shift_n   = {shift_q[6:0], 1'b0};
						bit_cnt_n = bit_cnt_q + 4'd1;
						delay_n   = delay_load;
						phase_n   = PH_W_LOW;
					end
				end
				PH_R_LOW: begin
					scl_n     = 1'b1;
					shift_n   = {shift_q[6:0], tick.sda_in};
					bit_cnt_n = bit_cnt_q + 4'd1;
					delay_n   = delay_load;
					phase_n   = PH_R_HIGH;
				end
				PH_R_HIGH: begin
					scl_n   = 1'b0;
					delay_n = delay_load;
					if (bit_cnt_q < BITS_PER_BYTE) begin
						phase_n = PH_R_LOW;
					end else begin
						sda_n   = ~ack_choice_q;
						phase_n = PH_A_LOW;
					end
				end
				PH_A_LOW: begin
					scl_n   = 1'b1;
					delay_n = delay_load;
					phase_n = PH_A_HIGH;
				end
				PH_A_HIGH: begin
					scl_n   = 1'b0;
					rx_n    = shift_q;
					phase_n = PH_IDLE;
					done_n  = 1'b1;
				end
				PH_K_REL: begin
					scl_n   = 1'b1;
					delay_n = delay_load;
					phase_n = PH_K_HIGH;
				end
				PH_K_HIGH: begin
					phase_n = PH_K_POLL;
					do_poll = 1'b1;
				end
				default: begin
					phase_n = PH_IDLE;
					done_n  = 1'b1;
				end
			endcase
		end else begin
			delay_n = delay_q - DELAY_WIDTH'(1);
		end

		// acknowledge poll: low sda ends the wait, too many high polls send a stop
		if (do_poll) begin
			if (!tick.sda_in) begin
				scl_n   = 1'b0;
				delay_n = '0;
				phase_n = PH_IDLE;
				done_n  = 1'b1;
			end else if (poll_q >= ack_timeout) begin
				fail_n  = 1'b1;
				scl_n   = 1'b0;
				sda_n   = 1'b0;
				delay_n = delay_load;
				phase_n = PH_P_A;
			end else begin
				poll_n = poll_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_cnt_q    <= '0;
			shift_q      <= '0;
			delay_q      <= '0;
			poll_q       <= '0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			fail_q       <= 1'b0;
			rx_q         <= '0;
			done_q       <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_n;
			bit_cnt_q    <= bit_cnt_n;
			shift_q      <= shift_n;
			delay_q      <= delay_n;
			poll_q       <= poll_n;
			ack_choice_q <= ack_choice_n;
			scl_q        <= scl_n;
			sda_q        <= sda_n;
			fail_q       <= fail_n;
			rx_q         <= rx_n;
			done_q       <= done_n;
		end
	end

	assign res.scl_out    = scl_q;
	assign res.sda_out    = sda_q;
	assign res.busy_res   = (phase_q != PH_IDLE);
	assign res.done_res   = done_q;
	assign res.rx_byte    = rx_q;
	assign res.ack_failed = fail_q;

endmodule

// ===== rtl/i2c_master_bit_engine_unit.sv =====
`timescale 1ns / 1ps

// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+--------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | one tick: command and sampled sda
// m_axis    | out | m_axis_tvalid/m_axis_tready  | pin drive levels and status
// cfg       | in  | cfg_we (no wait)             | half_period, ack_timeout
//
// one tick per clock cycle sustained while m_axis_tready holds: a tick lands in the input
// register, then the sequencer steps once from it into its state registers, which form the result
// a stalled result holds the sequencer; one more tick may wait in the input register
// arst_n clears the handshake state and resets the sequencer (idle, lines released) and config

module i2c_master_bit_engine_unit import i2cmbe_pkg::*; #(
	parameter int DELAY_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tx_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
	input  logic [15:0]         s_axis_tdata,
	// cmd_valid[0], op[3:1]
	input  logic [3:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4], ack_failed[12],
	// zero[15:13]
	output logic [15:0]         m_axis_tdata,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CfgWidth-1:0] cfg_data
);

	logic        in_valid_s1;
	tick_t       tick_s1;
	logic        out_valid_q;
	logic        step;
	logic [15:0] half_period_q;
	logic [7:0]  ack_timeout_q;
	result_t     res;

	// the sequencer steps when a tick is held and the result slot is free
	assign step          = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				in_valid_s1 <= s_axis_tvalid;
			if (step)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// tick payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tick_s1.cmd_valid <= s_axis_tuser[0];
			tick_s1.op        <= s_axis_tuser[3:1];
			tick_s1.tx_byte   <= s_axis_tdata[7:0];
			tick_s1.send_ack  <= s_axis_tdata[8];
			tick_s1.sda_in    <= s_axis_tdata[9];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_PERIOD: half_period_q <= cfg_data[15:0];
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	i2cmbe_seq #(
		.DELAY_WIDTH(DELAY_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.tick       (tick_s1),
		.half_period(half_period_q),
		.ack_timeout(ack_timeout_q),
		.res        (res)
	);

	// sequencer state doubles as the result register
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res.ack_failed, res.rx_byte, res.done_res,
		res.busy_res, res.sda_out, res.scl_out};

endmodule

// ===== rtl/i2cmbe_checker.sv =====
`timescale 1ns / 1ps

module i2cmbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// a finished command never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]))
		else $error("done and busy together");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// a fresh result follows an earlier tick transaction
	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without tick");

	// received byte only changes on the finishing tick of a read
	a_rx_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && $past(m_axis_tvalid) && !$stable(m_axis_tdata[11:4])
		|-> m_axis_tdata[3])
		else $error("rx byte changed without done");

	// an acknowledge timeout pulls both lines low to start the stop
	a_fail_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && $past(m_axis_tvalid) && $rose(m_axis_tdata[12])
		|-> !m_axis_tdata[0] && !m_axis_tdata[1] && m_axis_tdata[2])
		else $error("timeout without stop drive");

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_i2cmbe_checker (.*);
